// ----- hw/rtl/cks_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the color-key span encoder.
package cks_pkg;

  localparam int PIXEL_W     = 16;
  localparam int SPAN_W      = 12;
  localparam int OFFS_W      = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               line_end;
  } cks_in_t;

  typedef struct packed {
    logic [SPAN_W-1:0] span_word;
    logic              is_header;
    logic [OFFS_W-1:0] word_offset;
    logic              last;
  } cks_out_t;

  // Words caused by one pixel: a run ended by a change, the line's last run, the header.
  typedef struct packed {
    logic              has_change;
    logic [SPAN_W-1:0] change_span;
    logic [OFFS_W-1:0] change_off;
    logic              has_end;
    logic [SPAN_W-1:0] end_span;
    logic [OFFS_W-1:0] end_off;
    logic [SPAN_W-1:0] hdr_span;
  } cks_rec_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_END,
    PH_HDR
  } cks_phase_t;

endpackage

// ----- hw/rtl/cks_front.sv -----
`timescale 1ns / 1ps
// Front end: color-key register, pixel classification and run tracking.
module cks_front #(
  parameter int KEY_BITS       = 16,
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cks_pkg::cks_in_t     in_data,
  input  logic                 q_full,
  output logic                 push,
  output cks_pkg::cks_rec_t    push_rec
);
  import cks_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH + 1);

  logic [KEY_BITS-1:0] key;
  logic                mid_line, mid_line_next;
  logic                first_opaque, first_opaque_next;
  logic                run_opaque, run_opaque_next;
  logic [CW-1:0]       run_length, run_length_next;
  logic [CW-1:0]       run_count, run_count_next;
  logic                opaque;
  logic                accept;
  logic [CW-1:0]       chg_off;
  logic [CW-1:0]       end_off;
  logic [OFFS_W-1:0]   hdr_cnt;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    logic [CW-1:0] lim;
    lim = CW'(MAX_LINE_WIDTH);
    return (v >= lim) ? lim : v + CW'(1);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign opaque   = in_data.pixel[KEY_BITS-1:0] != key;
  assign push     = accept && (push_rec.has_change || push_rec.has_end);

  always_comb begin
    mid_line_next     = mid_line;
    first_opaque_next = first_opaque;
    run_opaque_next   = run_opaque;
    run_length_next   = run_length;
    run_count_next    = run_count;
    chg_off           = sat_inc(run_count);
    end_off           = '0;
    hdr_cnt           = '0;
    push_rec          = '0;
    if (!mid_line) begin
      first_opaque_next = opaque;
      run_opaque_next   = opaque;
      run_length_next   = CW'(1);
      run_count_next    = '0;
      mid_line_next     = 1'b1;
    end else if (opaque == run_opaque) begin
      run_length_next = sat_inc(run_length);
    end else begin
      push_rec.has_change  = 1'b1;
      push_rec.change_span = SPAN_W'(run_length);
      push_rec.change_off  = OFFS_W'(chg_off);
      run_count_next       = chg_off;
      run_length_next      = CW'(1);
      run_opaque_next      = opaque;
    end
    if (in_data.line_end) begin
      end_off           = sat_inc(run_count_next);
      hdr_cnt           = OFFS_W'(end_off);
      push_rec.has_end  = 1'b1;
      push_rec.end_span = SPAN_W'(run_length_next);
      push_rec.end_off  = OFFS_W'(end_off);
      push_rec.hdr_span = {hdr_cnt, first_opaque_next};
      run_count_next    = end_off;
      run_length_next   = '0;
      mid_line_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      mid_line     <= 1'b0;
      first_opaque <= 1'b0;
      run_opaque   <= 1'b0;
      run_length   <= '0;
      run_count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        key <= cfg_wr_data[KEY_BITS-1:0];
      end
      if (accept) begin
        mid_line     <= mid_line_next;
        first_opaque <= first_opaque_next;
        run_opaque   <= run_opaque_next;
        run_length   <= run_length_next;
        run_count    <= run_count_next;
      end
    end
  end

  a_line_closes: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.line_end |=> !mid_line)
    else $error("line end did not close the line");

  a_run_open: assert property (@(posedge clk) disable iff (rst)
    mid_line |-> run_length != '0)
    else $error("open line with empty run");

endmodule

// ----- hw/rtl/cks_queue.sv -----
`timescale 1ns / 1ps
// Short record queue between front and back.
module cks_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cks_pkg::cks_rec_t  push_rec,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output cks_pkg::cks_rec_t  head_rec
);
  import cks_pkg::*;

  cks_rec_t               store [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full      = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_rec  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/cks_back.sv -----
`timescale 1ns / 1ps
// Back end: splits queued records into words and drives the output register.
module cks_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  cks_pkg::cks_rec_t  head_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cks_pkg::cks_out_t  out_data
);
  import cks_pkg::*;

  cks_phase_t phase, phase_next;
  cks_out_t   word;
  logic       take;
  logic       done;

  assign take = q_not_empty && (!out_valid || out_ready);
  assign pop  = take && done;

  always_comb begin
    word       = '0;
    done       = 1'b0;
    phase_next = phase;
    case (phase)
      PH_FIRST: begin
        if (head_rec.has_change) begin
          word.span_word   = head_rec.change_span;
          word.word_offset = head_rec.change_off;
          word.last        = !head_rec.has_end;
          done             = !head_rec.has_end;
          phase_next       = head_rec.has_end ? PH_END : PH_FIRST;
        end else begin
          word.span_word   = head_rec.end_span;
          word.word_offset = head_rec.end_off;
          phase_next       = PH_HDR;
        end
      end
      PH_END: begin
        word.span_word   = head_rec.end_span;
        word.word_offset = head_rec.end_off;
        phase_next       = PH_HDR;
      end
      PH_HDR: begin
        word.span_word = head_rec.hdr_span;
        word.is_header = 1'b1;
        word.last      = 1'b1;
        done           = 1'b1;
        phase_next     = PH_FIRST;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= word;
    end
  end

  a_record_held: assert property (@(posedge clk) disable iff (rst)
    phase != PH_FIRST |-> q_not_empty)
    else $error("record left the queue before its last word");

  a_header_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_header |-> out_data.last && out_data.word_offset == '0)
    else $error("malformed header word");

endmodule

// ----- hw/rtl/colorkey_span_encoder_unit.sv -----
`timescale 1ns / 1ps
// Color-key span encoder, top level.
// Takes one pixel per cycle. A pixel that ends a run or a line leaves a record of
// one to three words (ended run, last run, header) in a four-entry queue; the back
// end drains that queue into the output register one word per cycle unless the
// receiver holds off, so the output rate of one word per cycle is what sets
// throughput. Pixels stall only when the queue is full, which happens when the
// receiver holds off or when lines or runs are short enough that the words
// outnumber the pixels. Words pass the queue, then the output register.
module colorkey_span_encoder_unit #(
  parameter int PIXEL_BITS     = 16,
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  cks_pkg::cks_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cks_pkg::cks_out_t  out_data
);
  import cks_pkg::*;

  localparam int KEY_BITS = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;
  cks_rec_t push_rec;
  cks_rec_t head_rec;

  cks_front #(
    .KEY_BITS       (KEY_BITS),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  cks_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  cks_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head_rec    (head_rec),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- tb/cks_span_checker.sv -----
`timescale 1ns / 1ps
// Span checker: predicts the span words for each pixel transfer and compares them.
module cks_span_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  cks_pkg::cks_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  cks_pkg::cks_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import cks_pkg::*;

  localparam int MAX_LW = 1024;

  logic [PIXEL_W-1:0] key_shadow = '0;
  bit                 mid_line, first_opaque, run_opaque;
  int unsigned        run_len, run_cnt;
  cks_out_t           span_words_due[$];
  cks_out_t           due;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned sat_step(int unsigned v);
    return (v >= MAX_LW) ? MAX_LW : v + 1;
  endfunction

  function automatic void push_word(int unsigned word, bit hdr, int unsigned offs);
    cks_out_t w;
    w.span_word   = SPAN_W'(word);
    w.is_header   = hdr;
    w.word_offset = OFFS_W'(offs);
    w.last        = 1'b0;
    span_words_due.push_back(w);
  endfunction

  function automatic void close_run();
    int unsigned offs;
    offs = sat_step(run_cnt);
    push_word(run_len, 1'b0, offs);
    run_cnt = offs;
  endfunction

  function automatic void encode_pixel(cks_in_t item);
    bit opaque;
    int n0;
    opaque = (item.pixel != key_shadow);
    n0     = span_words_due.size();
    if (!mid_line) begin
      first_opaque = opaque;
      run_opaque   = opaque;
      run_len      = 1;
      run_cnt      = 0;
      mid_line     = 1'b1;
    end else if (opaque == run_opaque) begin
      run_len = sat_step(run_len);
    end else begin
      close_run();
      run_len    = 1;
      run_opaque = opaque;
    end
    if (item.line_end) begin
      close_run();
      push_word((run_cnt << 1) | first_opaque, 1'b1, 0);
      mid_line = 1'b0;
      run_len  = 0;
    end
    if (span_words_due.size() > n0) span_words_due[span_words_due.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_shadow   = '0;
      mid_line     = 1'b0;
      first_opaque = 1'b0;
      run_opaque   = 1'b0;
      run_len      = 0;
      run_cnt      = 0;
      span_words_due.delete();
    end else begin
      if (in_valid && in_ready) encode_pixel(in_data);
      if (out_valid && out_ready) begin
        if (span_words_due.size() == 0) begin
          $error("unexpected span word transfer: %h", out_data);
          fail_count++;
        end else begin
          due = span_words_due.pop_front();
          check_field("span_word", 32'(due.span_word), 32'(out_data.span_word));
          check_field("is_header", 32'(due.is_header), 32'(out_data.is_header));
          check_field("word_offset", 32'(due.word_offset), 32'(out_data.word_offset));
          check_field("last", 32'(due.last), 32'(out_data.last));
        end
      end
      // new key applies from the next pixel on
      if (cfg_wr_en) key_shadow = cfg_wr_data;
    end
    pending = span_words_due.size();
  end

endmodule

// ----- tb/tb_colorkey_span_encoder_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the color-key span encoder: stimulus, flow control and verdict.
module tb_colorkey_span_encoder_unit;
  import cks_pkg::*;

  localparam int LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  cks_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  cks_out_t    out_data;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  logic        steady;
  logic        hold_req;
  logic        hold_done;
  logic [15:0] cur_key;

  always #5 clk = ~clk;

  colorkey_span_encoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  cks_span_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 13);
      end
    end
  end

  task automatic send_pixel(input logic [15:0] pix, input logic eol);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel: pix, line_end: eol};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_key(input logic [15:0] k);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    cur_key = k;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] opaque_pixel();
    logic [15:0] p;
    p = 16'($urandom);
    return (p == cur_key) ? ~cur_key : p;
  endfunction

  // mostly well-formed lines of runs, some raw noise pixels
  task automatic send_lines(input int n_items);
    int sent;
    int len;
    bit opq;
    logic [15:0] p;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      opq = 1'($urandom_range(0, 1));
      for (int i = 0; i < len && sent < n_items; i++) begin
        if ($urandom_range(0, 99) < 35) opq = !opq;
        if ($urandom_range(0, 9) == 0) p = 16'($urandom);
        else p = opq ? opaque_pixel() : cur_key;
        send_pixel(p, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    cur_key     = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_key(16'h0000);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'h0000, 1'b1);
    drain();
    set_key(16'hFFFF);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h7FFE, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    drain();
    // key change mid-line: the open run keeps its class
    set_key(16'h5A5A);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5A5A, 1'b0);
    send_pixel(16'h5A5A, 1'b1);

    drain();
    set_key(16'h0000);
    send_lines(75);

    drain();
    set_key(16'hFFFF);
    hold_req <= 1'b1;
    send_lines(75);

    drain();
    set_key(16'($urandom));
    steady <= 1'b1;
    send_lines(70);

    drain();
    steady <= 1'b0;
    set_key(16'h8000);
    send_lines(70);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
